/* rtl/flpa_pkg.sv */
// ----------------------------------------------------------------------------
// flpa_pkg: shared types and constants of the free-list pool allocator
// Request and response layouts, function codes, configuration register
// indexes and the interface of the shared multiply/divide unit.
// ----------------------------------------------------------------------------
package flpa_pkg;

  // Field widths fixed by the request and response formats
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LIVE_W     = 11;
  localparam int unsigned BSIZE_W    = 16;
  localparam int unsigned BALIGN_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Iteration counts of the shared unit
  localparam int unsigned MUL_STEPS = BSIZE_W;
  localparam int unsigned DIV_STEPS = ADDR_W;
  localparam int unsigned STEP_W    = 5;

  // Request function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_INIT  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_POOL_BYTES   = 2'd1,
    CFG_BLOCK_SIZE   = 2'd2,
    CFG_BLOCK_ALIGN  = 2'd3
  } cfg_idx_e;

  // Shared unit operation
  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_mode_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] block_address;
    logic [ADDR_W-1:0] used_bytes;
    logic [LIVE_W-1:0] live_blocks;
  } rsp_t;

  typedef struct packed {
    logic               start;
    alu_mode_e          mode;
    logic [ADDR_W-1:0]  opa;
    logic [BSIZE_W-1:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] value;
  } alu_rsp_t;

endpackage

/* rtl/flpa_alu.sv */
// ----------------------------------------------------------------------------
// flpa_alu: shared shift-add multiplier and restoring divider
// Multiplies a 32-bit operand by a 16-bit operand in 16 steps (low 32 bits
// kept), or divides a 32-bit dividend by a nonzero 16-bit divisor in 32
// steps. The result is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module flpa_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  flpa_pkg::alu_req_t req_i,
  output flpa_pkg::alu_rsp_t rsp_o
);
  import flpa_pkg::*;

  logic                run_q, run_d;
  logic                done_q, done_d;
  alu_mode_e           mode_q, mode_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic [ADDR_W-1:0]   acc_q, acc_d;
  logic [ADDR_W-1:0]   opa_q, opa_d;
  logic [BSIZE_W-1:0]  opb_q, opb_d;
  logic [BSIZE_W:0]    rem_q, rem_d;
  logic [BSIZE_W:0]    rem_sh;
  logic [BSIZE_W+1:0]  diff;

  // Partial remainder shifted by one dividend bit, and trial subtract
  assign rem_sh = {rem_q[BSIZE_W-1:0], acc_q[ADDR_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, opb_q};

  // Load on start, then step once per cycle
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      run_d  = 1'b1;
      mode_d = req_i.mode;
      opb_d  = req_i.opb;
      rem_d  = '0;
      if (req_i.mode == ALU_DIV) begin
        cnt_d = STEP_W'(DIV_STEPS - 1);
        acc_d = req_i.opa;
      end else begin
        cnt_d = STEP_W'(MUL_STEPS - 1);
        acc_d = '0;
        opa_d = req_i.opa;
      end
    end else if (run_q) begin
      if (mode_q == ALU_DIV) begin
        if (!diff[BSIZE_W+1]) begin
          rem_d = diff[BSIZE_W:0];
          acc_d = {acc_q[ADDR_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          acc_d = {acc_q[ADDR_W-2:0], 1'b0};
        end
      end else begin
        if (opb_q[0]) begin
          acc_d = acc_q + opa_q;
        end
        opa_d = {opa_q[ADDR_W-2:0], 1'b0};
        opb_d = {1'b0, opb_q[BSIZE_W-1:1]};
      end
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      mode_q <= ALU_MUL;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = acc_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !run_q)
    else $error("shared unit started while running");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && !req_i.start && cnt_q == '0) |=> (done_q && !run_q))
    else $error("shared unit did not finish after last step");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held longer than one cycle");

endmodule

/* rtl/free_list_pool_allocator.sv */
// ----------------------------------------------------------------------------
// free_list_pool_allocator: fixed-size block pool on a linked free list
// Allocate, free and initialize requests over a region set by configuration
// registers, with a next-link memory and one shared multiply/divide unit.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; exactly one
// response follows, on rsp_o for a single cycle with rsp_valid_o high, and
// the receiver must take it then because it cannot stall. An allocate that
// succeeds runs 16 multiply steps in the shared unit to form the block
// address; a free runs 32 divide steps to map the address to a block; an
// initialize divides likewise, then chains the free list one carved block
// per cycle through the single write port of the link memory. A failed
// allocate, a free with a zero block size, an initialize with a zero block
// size or with a region smaller than the alignment adjustment, and the
// unused function code go straight to the response.
// Configuration writes land at once and are only read by init.
module free_list_pool_allocator #(
  parameter int unsigned NUM_BLOCKS = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [flpa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [flpa_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 start,
  output logic                                 busy,
  input  flpa_pkg::req_t                       req_i,
  output logic                                 rsp_valid_o,
  output flpa_pkg::rsp_t                       rsp_o
);
  import flpa_pkg::*;

  // Index width holds the null index NUM_BLOCKS as well
  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned AW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(NUM_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_FILL = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  // Configuration registers
  logic [ADDR_W-1:0]   base_q;
  logic [ADDR_W-1:0]   pool_q;
  logic [BSIZE_W-1:0]  bsize_q;
  logic [BALIGN_W-1:0] balign_q;

  // Pool state
  state_e              state_q, state_d;
  func_e               func_q, func_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]    total_q, total_d;
  logic [IDX_W-1:0]    fill_q, fill_d;
  logic [ADDR_W-1:0]   first_q, first_d;
  logic [BSIZE_W-1:0]  blk_q, blk_d;
  logic [ADDR_W-1:0]   used_q, used_d;
  logic [LIVE_W-1:0]   live_q, live_d;
  logic                status_q, status_d;
  logic [ADDR_W-1:0]   res_addr_q, res_addr_d;

  // Link memory ports
  logic [IDX_W-1:0]    link_mem [NUM_BLOCKS];
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr;
  logic [IDX_W-1:0]    mem_wdata;
  logic [IDX_W-1:0]    rdata_q;

  // Shared unit
  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  // Init helpers and counter arithmetic
  logic [BALIGN_W-1:0] align_mask;
  logic [BALIGN_W-1:0] adj;
  logic [ADDR_W:0]     used_sum;
  logic [IDX_W-1:0]    fill_nxt;
  logic [IDX_W-1:0]    carve_cnt;

  flpa_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // Alignment adjustment; an alignment of zero counts as one
  assign align_mask = (balign_q == '0) ? '0 : balign_q - BALIGN_W'(1);
  assign adj        = (BALIGN_W'(0) - base_q[BALIGN_W-1:0]) & align_mask;
  assign used_sum   = {1'b0, used_q} + (ADDR_W + 1)'(blk_q);
  assign fill_nxt   = fill_q + IDX_W'(1);
  assign carve_cnt  = (alu_rsp.value > ADDR_W'(NUM_BLOCKS)) ? NULL_IDX
                                                            : alu_rsp.value[IDX_W-1:0];

  // Sequencer
  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    head_d     = head_q;
    total_d    = total_q;
    fill_d     = fill_q;
    first_d    = first_q;
    blk_d      = blk_q;
    used_d     = used_q;
    live_d     = live_q;
    status_d   = status_q;
    res_addr_d = res_addr_q;
    alu_req    = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = fill_q[AW-1:0];
    mem_wdata  = fill_nxt;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          func_d     = func_e'(req_i.func);
          status_d   = 1'b0;
          res_addr_d = '0;
          state_d    = S_RESP;
          case (func_e'(req_i.func))
            FUNC_ALLOC: begin
              if (head_q < total_q) begin
                alu_req.start = 1'b1;
                alu_req.mode  = ALU_MUL;
                alu_req.opa   = ADDR_W'(head_q);
                alu_req.opb   = blk_q;
                mem_re        = 1'b1;
                state_d       = S_CALC;
              end else begin
                status_d = 1'b1;
              end
            end
            FUNC_FREE: begin
              if (blk_q != '0) begin
                alu_req.start = 1'b1;
                alu_req.mode  = ALU_DIV;
                alu_req.opa   = req_i.free_address - first_q;
                alu_req.opb   = blk_q;
                state_d       = S_CALC;
              end
            end
            FUNC_INIT: begin
              first_d = base_q + ADDR_W'(adj);
              blk_d   = bsize_q;
              used_d  = '0;
              live_d  = '0;
              if (bsize_q != '0 && pool_q >= ADDR_W'(adj)) begin
                alu_req.start = 1'b1;
                alu_req.mode  = ALU_DIV;
                alu_req.opa   = pool_q - ADDR_W'(adj);
                alu_req.opb   = bsize_q;
                state_d       = S_CALC;
              end else begin
                total_d = '0;
                head_d  = NULL_IDX;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_CALC: begin
        if (alu_rsp.done) begin
          state_d = S_RESP;
          case (func_q)
            FUNC_ALLOC: begin
              // Pop the head and count the block as used
              res_addr_d = first_q + alu_rsp.value;
              head_d     = rdata_q;
              used_d     = used_sum[ADDR_W] ? '1 : used_sum[ADDR_W-1:0];
              if (live_q != '1) begin
                live_d = live_q + LIVE_W'(1);
              end
            end
            FUNC_FREE: begin
              // Push the block only when it lies inside the carved range
              if (alu_rsp.value < ADDR_W'(total_q)) begin
                mem_we    = 1'b1;
                mem_waddr = alu_rsp.value[AW-1:0];
                mem_wdata = head_q;
                head_d    = alu_rsp.value[IDX_W-1:0];
                used_d    = (used_q >= ADDR_W'(blk_q)) ? used_q - ADDR_W'(blk_q) : '0;
                if (live_q != '0) begin
                  live_d = live_q - LIVE_W'(1);
                end
              end
            end
            FUNC_INIT: begin
              total_d = carve_cnt;
              fill_d  = '0;
              if (carve_cnt != '0) begin
                head_d  = '0;
                state_d = S_FILL;
              end else begin
                head_d = NULL_IDX;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_FILL: begin
        // Chain one block per cycle in ascending order
        mem_we    = 1'b1;
        mem_waddr = fill_q[AW-1:0];
        mem_wdata = (fill_nxt == total_q) ? NULL_IDX : fill_nxt;
        fill_d    = fill_nxt;
        if (fill_nxt == total_q) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      pool_q   <= '0;
      bsize_q  <= BSIZE_W'(16);
      balign_q <= BALIGN_W'(8);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_ADDRESS: base_q   <= cfg_wdata_i;
        CFG_POOL_BYTES:   pool_q   <= cfg_wdata_i;
        CFG_BLOCK_SIZE:   bsize_q  <= cfg_wdata_i[BSIZE_W-1:0];
        CFG_BLOCK_ALIGN:  balign_q <= cfg_wdata_i[BALIGN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control and pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      func_q  <= FUNC_NOP;
      head_q  <= NULL_IDX;
      total_q <= '0;
      fill_q  <= '0;
      first_q <= '0;
      blk_q   <= '0;
      used_q  <= '0;
      live_q  <= '0;
    end else begin
      state_q <= state_d;
      func_q  <= func_d;
      head_q  <= head_d;
      total_q <= total_d;
      fill_q  <= fill_d;
      first_q <= first_d;
      blk_q   <= blk_d;
      used_q  <= used_d;
      live_q  <= live_d;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    res_addr_q <= res_addr_d;
  end

  // Link memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= link_mem[head_q[AW-1:0]];
    end
  end

  assign busy                = (state_q != S_IDLE);
  assign rsp_valid_o         = (state_q == S_RESP);
  assign rsp_o.status        = status_q;
  assign rsp_o.block_address = res_addr_q;
  assign rsp_o.used_bytes    = used_q;
  assign rsp_o.live_blocks   = live_q;

  a_rsp_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o)
    else $error("response held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (head_q == NULL_IDX || head_q < total_q))
    else $error("free list head outside carved blocks");

  a_init_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && func_q == FUNC_INIT) |-> (used_q == '0 && live_q == '0))
    else $error("init left usage counters nonzero");

endmodule

/* sim/tb_free_list_pool_allocator.sv */
// ----------------------------------------------------------------------------
// tb_free_list_pool_allocator: self-checking bench for the block pool allocator
// Drives allocate, free, init and no-op requests through the start/busy
// handshake, predicts each response from a local copy of the free list and
// the configuration, and compares every response field by field.
// ----------------------------------------------------------------------------
module tb_free_list_pool_allocator;
  import flpa_pkg::*;

  localparam int unsigned NUM_BLOCKS  = 1024;
  localparam int unsigned CYCLE_LIMIT = 10000000;
  localparam int unsigned RANDOM_REQS = 1650;
  localparam int unsigned MAX_PRINTS  = 100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  start;
  logic                  busy;
  req_t                  req;
  logic                  rsp_valid;
  rsp_t                  rsp;

  free_list_pool_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp)
  );

  // Local copy of the configuration registers
  logic [31:0] cfg_base;
  logic [31:0] cfg_pool;
  logic [15:0] cfg_bsize;
  logic [7:0]  cfg_align;

  // Local copy of the pool state
  int unsigned link_mem [NUM_BLOCKS];
  int unsigned pool_head;
  int unsigned pool_total;
  int unsigned pool_live;
  logic [31:0] pool_first;
  logic [31:0] pool_used;
  logic [31:0] pool_blk;

  rsp_t        pending_rsp_q [$];
  logic [31:0] live_addr_q [$];
  logic [31:0] last_freed;
  int unsigned mismatch_count;
  int unsigned reqs_sent;
  int unsigned burst_left;
  int unsigned cycle_count;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: fail and end the run once the cycle limit is reached
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Pool predictor
  // ---------------------------------------------------------------------------

  function automatic void pool_reset();
    cfg_base   = '0;
    cfg_pool   = '0;
    cfg_bsize  = 16'd16;
    cfg_align  = 8'd8;
    foreach (link_mem[i]) link_mem[i] = 0;
    pool_head  = NUM_BLOCKS;
    pool_total = 0;
    pool_live  = 0;
    pool_first = '0;
    pool_used  = '0;
    pool_blk   = '0;
    live_addr_q.delete();
    last_freed = '0;
  endfunction

  // Align the base, carve blocks and chain them in ascending order
  function automatic void pool_carve();
    logic [31:0] align;
    logic [31:0] adj;
    logic [31:0] count;
    align = {24'd0, cfg_align};
    if (align == 0) align = 32'd1;
    adj        = (32'd0 - cfg_base) & (align - 32'd1);
    pool_blk   = {16'd0, cfg_bsize};
    pool_first = cfg_base + adj;
    count      = '0;
    if (pool_blk != 0 && cfg_pool >= adj) begin
      count = (cfg_pool - adj) / pool_blk;
      if (count > NUM_BLOCKS) count = NUM_BLOCKS;
    end
    pool_total = count;
    for (int unsigned i = 0; i < count; i++)
      link_mem[i] = (i + 1 < count) ? i + 1 : NUM_BLOCKS;
    pool_head = (count != 0) ? 0 : NUM_BLOCKS;
    pool_used = '0;
    pool_live = 0;
    live_addr_q.delete();
  endfunction

  function automatic rsp_t pool_predict(req_t rq);
    rsp_t        rs;
    logic [31:0] idx;
    rs = '0;
    case (func_e'(rq.func))
      FUNC_ALLOC: begin
        if (pool_head < pool_total && pool_head < NUM_BLOCKS) begin
          rs.block_address = pool_first + pool_head * pool_blk;
          live_addr_q.push_back(rs.block_address);
          pool_head = link_mem[pool_head];
          if (pool_head > NUM_BLOCKS) pool_head = NUM_BLOCKS;
          pool_used = (pool_used > 32'hFFFF_FFFF - pool_blk) ? 32'hFFFF_FFFF
                                                             : pool_used + pool_blk;
          if (pool_live < 2047) pool_live++;
        end else begin
          rs.status = 1'b1;
        end
      end
      FUNC_FREE: begin
        if (pool_blk != 0) begin
          idx = (rq.free_address - pool_first) / pool_blk;
          if (idx < pool_total && idx < NUM_BLOCKS) begin
            link_mem[idx] = pool_head;
            pool_head     = idx;
            pool_used     = (pool_used >= pool_blk) ? pool_used - pool_blk : '0;
            if (pool_live > 0) pool_live--;
          end
        end
      end
      FUNC_INIT: pool_carve();
      default: ;
    endcase
    rs.used_bytes  = pool_used;
    rs.live_blocks = LIVE_W'(pool_live);
    return rs;
  endfunction

  // ---------------------------------------------------------------------------
  // Response checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_response(input rsp_t got);
    rsp_t want;
    if (pending_rsp_q.size() == 0) begin
      report_mismatch("response with no request outstanding", got.block_address, '0);
    end else begin
      want = pending_rsp_q.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.block_address !== want.block_address)
        report_mismatch("block_address", got.block_address, want.block_address);
      if (got.used_bytes !== want.used_bytes)
        report_mismatch("used_bytes", got.used_bytes, want.used_bytes);
      if (got.live_blocks !== want.live_blocks)
        report_mismatch("live_blocks", 32'(got.live_blocks), 32'(want.live_blocks));
    end
  endtask

  // Sample every response at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid) check_response(rsp);
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Hold the request until the edge that takes it; leave start high on return
  task automatic send_request(input func_e f, input logic [31:0] addr);
    req_t rq;
    rq.func         = f;
    rq.free_address = addr;
    start <= 1'b1;
    req   <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_rsp_q.push_back(pool_predict(rq));
    reqs_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Send in bursts of random length with random gaps between them
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 45);
      endcase
      if (gap > 0) idle_cycles(gap);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // Drop start and let every outstanding response arrive
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_BASE_ADDRESS: cfg_base  = value;
      CFG_POOL_BYTES:   cfg_pool  = value;
      CFG_BLOCK_SIZE:   cfg_bsize = value[15:0];
      CFG_BLOCK_ALIGN:  cfg_align = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_pool_cfg(input logic [31:0] base, input logic [31:0] bytes,
                                input logic [31:0] bsize, input logic [31:0] align);
    write_cfg(CFG_BASE_ADDRESS, base);
    write_cfg(CFG_POOL_BYTES, bytes);
    write_cfg(CFG_BLOCK_SIZE, bsize);
    write_cfg(CFG_BLOCK_ALIGN, align);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Requests against the pool as it comes out of reset
  task automatic test_reset_state();
    send_request(FUNC_ALLOC, 32'h0);
    send_request(FUNC_FREE, 32'hFFFF_FFFF);
    send_request(FUNC_NOP, 32'hA5A5_5A5A);
    send_request(FUNC_INIT, 32'h5A5A_A5A5);
    wait_idle();
  endtask

  // Three blocks: drain, overflow, misaligned, out-of-range and double free
  task automatic test_basic_chain();
    write_pool_cfg(32'h0000_1003, 32'd20, 32'd4, 32'd8);
    send_request(FUNC_INIT, 32'h0);
    repeat (4) send_request(FUNC_ALLOC, 32'h0);
    send_request(FUNC_FREE, 32'h0000_100E);
    send_request(FUNC_FREE, 32'h0000_1000);
    send_request(FUNC_FREE, 32'h0000_1014);
    send_request(FUNC_FREE, 32'h0000_100D);
    send_request(FUNC_ALLOC, 32'h0);
    send_request(FUNC_ALLOC, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    // Largest region and block: the count caps at NUM_BLOCKS
    write_pool_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd128);
    send_request(FUNC_INIT, 32'h0);
    send_request(FUNC_ALLOC, 32'h0);
    send_request(FUNC_FREE, pool_first + (NUM_BLOCKS - 1) * pool_blk + pool_blk - 1);
    wait_idle();
    // Alignment that is not a power of two
    write_pool_cfg(32'h0000_0001, 32'h0000_0200, 32'd4, 32'hFF);
    send_request(FUNC_INIT, 32'h0);
    send_request(FUNC_ALLOC, 32'h0);
    wait_idle();
    // Zero block size with zero alignment gives an empty pool
    write_pool_cfg(32'h0, 32'h0000_1000, 32'h0, 32'h0);
    send_request(FUNC_INIT, 32'h0);
    send_request(FUNC_FREE, 32'h0000_0010);
    send_request(FUNC_ALLOC, 32'h0);
    wait_idle();
    // Region smaller than the alignment adjustment
    write_pool_cfg(32'h0000_0001, 32'd100, 32'd4, 32'd128);
    send_request(FUNC_INIT, 32'h0);
    send_request(FUNC_ALLOC, 32'h0);
    wait_idle();
  endtask

  // Free with nothing in use, then loop one block well past the block count
  task automatic test_counter_limits();
    write_pool_cfg(32'h0, 32'h0001_FFFE, 32'h0000_FFFF, 32'd1);
    send_request(FUNC_INIT, 32'h0);
    pace();
    repeat (2) begin
      send_request(FUNC_FREE, 32'h0000_0004);
      pace();
    end
    repeat (40) begin
      send_request(FUNC_ALLOC, $urandom);
      pace();
    end
    send_request(FUNC_FREE, 32'h0);
    wait_idle();
  endtask

  // Pick a configuration for one random phase
  task automatic pick_random_config();
    logic [31:0] base;
    logic [31:0] bsize;
    logic [31:0] align;
    logic [31:0] adj;
    int unsigned mode;
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      write_pool_cfg($urandom, $urandom, $urandom, $urandom);
    end else if (mode == 1) begin
      // Degenerate settings
      case ($urandom_range(0, 2))
        0:       write_pool_cfg($urandom, $urandom, 32'h0, $urandom_range(0, 255));
        1:       write_pool_cfg($urandom | 32'h1, $urandom_range(0, 126), 32'd4, 32'd128);
        default: write_pool_cfg($urandom, $urandom_range(0, 64), $urandom_range(4, 64), 32'h0);
      endcase
    end else begin
      base  = (mode == 2) ? 32'hFFFF_FFFF - $urandom_range(0, 4095) : $urandom;
      bsize = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 65535) : $urandom_range(4, 64);
      align = 32'd1 << $urandom_range(0, 7);
      adj   = (32'd0 - base) & (align - 32'd1);
      write_pool_cfg(base, adj + $urandom_range(1, 48) * bsize + $urandom_range(0, bsize - 1),
                     bsize, align);
    end
  endtask

  // One random request, mostly well-formed allocate/free traffic
  task automatic random_request();
    int unsigned sel;
    int unsigned k;
    logic [31:0] addr;
    logic [31:0] off;
    sel = $urandom_range(0, 99);
    off = (pool_blk > 1) ? $urandom_range(0, pool_blk - 1) : '0;
    if (sel < 42 || (sel < 72 && live_addr_q.size() == 0)) begin
      send_request(FUNC_ALLOC, $urandom);
    end else if (sel < 72) begin
      k    = $urandom_range(0, live_addr_q.size() - 1);
      addr = live_addr_q[k];
      live_addr_q.delete(k);
      last_freed = addr;
      send_request(FUNC_FREE, addr + off);
    end else if (sel < 80) begin
      send_request(FUNC_FREE, $urandom);
    end else if (sel < 85) begin
      send_request(FUNC_FREE, last_freed);
    end else if (sel < 90 && pool_total != 0) begin
      send_request(FUNC_FREE,
                   pool_first + $urandom_range(0, pool_total - 1) * pool_blk + off);
    end else if (sel < 97) begin
      send_request(FUNC_NOP, $urandom);
    end else begin
      send_request(FUNC_INIT, $urandom);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    target = reqs_sent + RANDOM_REQS;
    while (reqs_sent < target) begin
      wait_idle();
      pick_random_config();
      send_request(FUNC_INIT, $urandom);
      pace();
      repeat ($urandom_range(30, 90)) begin
        random_request();
        pace();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    req            = '0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_BASE_ADDRESS;
    cfg_wdata      = '0;
    mismatch_count = 0;
    reqs_sent      = 0;
    burst_left     = 1;
    pool_reset();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_basic_chain();
    test_config_extremes();
    test_counter_limits();
    test_random_traffic();

    // Drain and let the block settle
    wait_idle();
    repeat (40) @(negedge clk_i);
    if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* free_list_pool_allocator.f */
rtl/flpa_pkg.sv
rtl/flpa_alu.sv
rtl/free_list_pool_allocator.sv
sim/tb_free_list_pool_allocator.sv
